### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files of the HSV to RGB converter.
// Needs nothing else; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, skipped while reset is high
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   `ASSERT_PROP(label, clk, rst, (ante) |-> (cons), msg)

`endif

### rtl/core/hsvrgb_pkg.sv
// Package of the HSV to RGB converter: sector codes, fixed-point constants
// and the stage records passed between modules. Depends on nothing.
package hsvrgb_pkg;

   // Hue sector codes, in order around the color wheel
   localparam logic [2:0] SEC_RED_TO_YELLOW   = 3'd0;
   localparam logic [2:0] SEC_YELLOW_TO_GREEN = 3'd1;
   localparam logic [2:0] SEC_GREEN_TO_CYAN   = 3'd2;
   localparam logic [2:0] SEC_CYAN_TO_BLUE    = 3'd3;
   localparam logic [2:0] SEC_BLUE_TO_MAGENTA = 3'd4;
   localparam logic [2:0] SEC_MAGENTA_TO_RED  = 3'd5;

   // Fixed-point constants: fractions have denominator 255 or 255*255
   localparam int          SECTOR_COUNT = 6;
   localparam logic [7:0]  BYTE_MAX     = 8'd255;
   localparam logic [15:0] HALF_BYTE    = 16'd127;
   localparam logic [23:0] HALF_SQ      = 24'd32512;
   // ceil(2^32 / 255): exact floor(z / 255) for every z below 2^24
   localparam logic [24:0] RECIP_255    = 25'd16843010;

   typedef logic [2:0] sector_type;

   // Hue decoded into sector and fraction, with saturation and value
   typedef struct packed {
      sector_type sector;
      logic [7:0] frac;
      logic [7:0] sat;
      logic [7:0] val;
   } hue_stage_type;

   // The four candidate levels and the sector that picks among them
   typedef struct packed {
      sector_type sector;
      logic [7:0] val;
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] t;
   } level_stage_type;

endpackage

### rtl/core/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: stream ports, valid pipeline,
// output select. Depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_levels, assert_macros.svh.
//
// Usage:
//   req_* carries one pixel per item: hue, saturation and brightness bytes.
//   rsp_* carries one converted pixel per item: red, green and blue bytes.
//   Every accepted request item gives exactly one response item, in order.
//   The response to an accepted request shows on rsp_tvalid once it has
//   passed every register stage. Throughput: one item per cycle unless the
//   receiver stalls; six register stages (hue decode, four arithmetic
//   stages, output register) all advance together.
//   Stall: while rsp_tvalid is high and rsp_tready low, the whole pipeline
//   holds and req_tready is low; an empty output register lets the
//   pipeline move on even while the receiver stalls.
//   Reset: synchronous, active high; clears all valid bits and holds
//   req_tready low, so the pipeline comes out of reset empty and ready.
`include "assert_macros.svh"

module hsv_to_rgb_converter
   import hsvrgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // hue [7:0], saturation [15:8], brightness [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red [7:0], green [15:8], blue [23:16]
);

   localparam int STAGES = 6;

   logic [STAGES-1:0] valid_ff, valid_in;
   hue_stage_type     hue_ff, hue_in;
   level_stage_type   level_stage;
   logic [23:0]       rgb_ff, rgb_in;
   logic              advance;
   sector_type        sector;
   logic [7:0]        frac;
   logic [7:0]        red, green, blue;

   // Move everything when the output is empty or being taken
   assign advance    = !valid_ff[STAGES-1] || rsp_tready;
   assign req_tready = advance && !reset;

   hsvrgb_sector u_sector (
      .hue    (req_tdata[7:0]),
      .sector (sector),
      .frac   (frac)
   );

   always_comb begin
      hue_in.sector = sector;
      hue_in.frac   = frac;
      hue_in.sat    = req_tdata[15:8];
      hue_in.val    = req_tdata[23:16];
   end

   hsvrgb_levels u_levels (
      .clock       (clock),
      .advance     (advance),
      .hue_stage   (hue_ff),
      .level_stage (level_stage)
   );

   // Route value and levels to the channels by sector
   always_comb begin
      case (level_stage.sector)
         SEC_RED_TO_YELLOW: begin
            red = level_stage.val; green = level_stage.t;   blue = level_stage.p;
         end
         SEC_YELLOW_TO_GREEN: begin
            red = level_stage.q;   green = level_stage.val; blue = level_stage.p;
         end
         SEC_GREEN_TO_CYAN: begin
            red = level_stage.p;   green = level_stage.val; blue = level_stage.t;
         end
         SEC_CYAN_TO_BLUE: begin
            red = level_stage.p;   green = level_stage.q;   blue = level_stage.val;
         end
         SEC_BLUE_TO_MAGENTA: begin
            red = level_stage.t;   green = level_stage.p;   blue = level_stage.val;
         end
         default: begin
            red = level_stage.val; green = level_stage.p;   blue = level_stage.q;
         end
      endcase
      rgb_in = {blue, green, red};
   end

   // Shift valid bits along with the data
   assign valid_in = {valid_ff[STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers hold on a stall
   always_ff @(posedge clock) begin
      if (advance) begin
         hue_ff <= hue_in;
         rgb_ff <= rgb_in;
      end
   end

   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = rgb_ff;

   // Qualified handshake terms for the latency check
   logic acc_clean, ready_clean;
   assign acc_clean   = req_tvalid && req_tready && !reset;
   assign ready_clean = rsp_tready && !reset;

   `ASSERT_IMPL(sector_in_range, clock, reset, valid_ff[0], hue_ff.sector <= SEC_MAGENTA_TO_RED, "hue sector out of range")
   `ASSERT_IMPL(levels_bounded, clock, reset, valid_ff[STAGES-2], (level_stage.p <= level_stage.val) && (level_stage.q <= level_stage.val) && (level_stage.t <= level_stage.val), "level exceeds value")
   `ASSERT_IMPL(full_turn_wraps, clock, reset, valid_ff[0] && $past(acc_clean) && ($past(req_tdata[7:0]) == BYTE_MAX), (hue_ff.sector == SEC_RED_TO_YELLOW) && (hue_ff.frac == 8'd0), "full hue did not wrap")
   `ASSERT_IMPL(fixed_latency, clock, reset, $past(acc_clean, 6) && $past(ready_clean, 5) && $past(ready_clean, 4) && $past(ready_clean, 3) && $past(ready_clean, 2) && $past(ready_clean, 1), rsp_tvalid, "response missing after pipeline latency")

endmodule

### rtl/core/hsvrgb_sector.sv
// Hue decoder of the HSV to RGB converter: splits hue*6 into sector and
// fraction in units of 1/255. Depends on hsvrgb_pkg.
module hsvrgb_sector
   import hsvrgb_pkg::*;
(
   input  logic [7:0] hue,
   output sector_type sector,
   output logic [7:0] frac
);

   logic [10:0] h6;
   logic [10:0] base;
   sector_type  sec;

   assign h6 = 11'(hue) * 11'd6;

   // Count the sector boundaries passed, then take the remainder
   always_comb begin
      sec = SEC_RED_TO_YELLOW;
      for (int k = 1; k < SECTOR_COUNT; k++) begin
         if (h6 >= 11'(k * 255)) begin
            sec = 3'(k);
         end
      end
      base = 11'(sec) * 11'(BYTE_MAX);
      if (h6 >= 11'(SECTOR_COUNT * 255)) begin
         // A full turn wraps back to the start of the first sector
         sector = SEC_RED_TO_YELLOW;
         frac   = 8'd0;
      end else begin
         sector = sec;
         frac   = 8'(h6 - base);
      end
   end

endmodule

### rtl/core/hsvrgb_levels.sv
// Arithmetic pipeline of the HSV to RGB converter: forms the levels p, q
// and t over four register stages. Depends on hsvrgb_pkg.
module hsvrgb_levels
   import hsvrgb_pkg::*;
(
   input  logic            clock,
   input  logic            advance,
   input  hue_stage_type   hue_stage,
   output level_stage_type level_stage
);

   typedef struct packed {
      sector_type  sector;
      logic [7:0]  val;
      logic [15:0] sf;
      logic [15:0] snf;
      logic [15:0] pn;
   } prod_type;

   typedef struct packed {
      sector_type  sector;
      logic [7:0]  val;
      logic [7:0]  p;
      logic [23:0] zq;
      logic [23:0] zt;
   } wide_type;

   typedef struct packed {
      sector_type  sector;
      logic [7:0]  val;
      logic [7:0]  p;
      logic [15:0] aq;
      logic [15:0] at;
   } quot_type;

   prod_type        prod_ff, prod_in;
   wide_type        wide_ff, wide_in;
   quot_type        quot_ff, quot_in;
   level_stage_type level_ff, level_in;
   logic [47:0]     mq, mt;

   // floor(x / 255) for x below 255*256, by multiply with 257
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [24:0] m;
      m = (25'(x) + 25'd1) * 25'd257;
      return m[23:16];
   endfunction

   // Stage one: the products sat*frac, sat*(255-frac) and val*(255-sat)
   always_comb begin
      prod_in.sector = hue_stage.sector;
      prod_in.val    = hue_stage.val;
      prod_in.sf     = 16'(hue_stage.sat) * 16'(hue_stage.frac);
      prod_in.snf    = 16'(hue_stage.sat) * 16'(BYTE_MAX - hue_stage.frac);
      prod_in.pn     = 16'(hue_stage.val) * 16'(BYTE_MAX - hue_stage.sat) + HALF_BYTE;
   end

   // Stage two: scale by value and add half for rounding; finish p
   always_comb begin
      wide_in.sector = prod_ff.sector;
      wide_in.val    = prod_ff.val;
      wide_in.p      = div255(prod_ff.pn);
      wide_in.zq     = 24'(prod_ff.val) * 24'(prod_ff.sf) + HALF_SQ;
      wide_in.zt     = 24'(prod_ff.val) * 24'(prod_ff.snf) + HALF_SQ;
   end

   // Stage three: first divide by 255 through the reciprocal
   assign mq = 48'(wide_ff.zq) * 48'(RECIP_255);
   assign mt = 48'(wide_ff.zt) * 48'(RECIP_255);

   always_comb begin
      quot_in.sector = wide_ff.sector;
      quot_in.val    = wide_ff.val;
      quot_in.p      = wide_ff.p;
      quot_in.aq     = mq[47:32];
      quot_in.at     = mt[47:32];
   end

   // Stage four: second divide by 255, then subtract the drop from value
   always_comb begin
      level_in.sector = quot_ff.sector;
      level_in.val    = quot_ff.val;
      level_in.p      = quot_ff.p;
      level_in.q      = quot_ff.val - div255(quot_ff.aq);
      level_in.t      = quot_ff.val - div255(quot_ff.at);
   end

   // Advance all stages together; hold them on a stall
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         wide_ff  <= wide_in;
         quot_ff  <= quot_in;
         level_ff <= level_in;
      end
   end

   assign level_stage = level_ff;

endmodule

### sim/hsv_to_rgb_converter_tb.sv
// Testbench for the HSV to RGB converter: drives pixels on the req_ stream and
// checks each converted pixel on the rsp_ stream against a local predictor.
// Depends on hsvrgb_pkg and hsv_to_rgb_converter.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
   import hsvrgb_pkg::*;

   localparam int unsigned FRAC_ONE    = 255;
   localparam int unsigned FRAC_ONE_SQ = 65025;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          HOLD_CYCLES  = 60;

   // Converted pixel, packed the way rsp_tdata carries it
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // hue [7:0], saturation [15:8], brightness [23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // red [7:0], green [15:8], blue [23:16]

   rgb_pixel_type expected_rgb_q[$];
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         hold_left = 0;
   int         pixels_sent = 0;
   int         pixels_checked = 0;
   int         mismatch_count = 0;

   hsv_to_rgb_converter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Six-sector conversion with levels rounded to the nearest byte
   function automatic rgb_pixel_type convert_hsv(input logic [7:0] hue, sat, val);
      int unsigned hue6;
      int unsigned frac;
      int unsigned lvl_p;
      int unsigned lvl_q;
      int unsigned lvl_t;
      sector_type  sector;
      rgb_pixel_type pix;
      hue6   = hue * 6;
      sector = sector_type'(hue6 / FRAC_ONE);
      frac   = hue6 % FRAC_ONE;
      // Full turn wraps back to the red sector
      if (hue6 / FRAC_ONE >= SECTOR_COUNT) begin
         sector = SEC_RED_TO_YELLOW;
         frac   = 0;
      end
      lvl_p = (val * (FRAC_ONE - sat) + 127) / FRAC_ONE;
      lvl_q = (val * (FRAC_ONE_SQ - sat * frac) + 32512) / FRAC_ONE_SQ;
      lvl_t = (val * (FRAC_ONE_SQ - sat * (FRAC_ONE - frac)) + 32512) / FRAC_ONE_SQ;
      case (sector)
         SEC_RED_TO_YELLOW: begin
            pix.red = val;         pix.green = lvl_t[7:0]; pix.blue = lvl_p[7:0];
         end
         SEC_YELLOW_TO_GREEN: begin
            pix.red = lvl_q[7:0];  pix.green = val;        pix.blue = lvl_p[7:0];
         end
         SEC_GREEN_TO_CYAN: begin
            pix.red = lvl_p[7:0];  pix.green = val;        pix.blue = lvl_t[7:0];
         end
         SEC_CYAN_TO_BLUE: begin
            pix.red = lvl_p[7:0];  pix.green = lvl_q[7:0]; pix.blue = val;
         end
         SEC_BLUE_TO_MAGENTA: begin
            pix.red = lvl_t[7:0];  pix.green = lvl_p[7:0]; pix.blue = val;
         end
         default: begin
            pix.red = val;         pix.green = lvl_p[7:0]; pix.blue = lvl_q[7:0];
         end
      endcase
      return pix;
   endfunction

   // Bias random bytes toward the range ends
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd1;
         3: return 8'd254;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Offer one pixel after a random idle stretch; hold it until accepted
   task automatic send_pixel(input logic [7:0] hue, sat, val);
      logic accepted;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {val, sat, hue};
      accepted = 1'b0;
      while (!accepted) begin
         @(negedge clock);
         accepted = req_tready;
         if (accepted)
            expected_rgb_q.push_back(convert_hsv(hue, sat, val));
         @(posedge clock);
      end
      pixels_sent++;
   endtask

   // Stop offering and wait for every pending pixel to come out
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (expected_rgb_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Range ends, every sector boundary, grey and full-turn hues
   task automatic test_directed_pixels();
      logic [7:0] bound_hues[13] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd127, 8'd128,
                                     8'd170, 8'd171, 8'd212, 8'd213, 8'd254, 8'd255};
      idle_pct  = 0;
      stall_pct = 0;
      foreach (bound_hues[i])
         send_pixel(bound_hues[i], 8'd255, 8'd255);
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd100, 8'd0,   8'd200);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd128, 8'd77);
      send_pixel(8'd0,   8'd128, 8'd77);
      send_pixel(8'hAA,  8'h55,  8'hAA);
      send_pixel(8'h55,  8'hAA,  8'h55);
      send_pixel(8'd30,  8'd1,   8'd254);
      wait_results_drained();
   endtask

   // Random pixels under one idle and stall mix
   task automatic test_random_pixels(input int count, input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count)
         send_pixel(pick_byte(), pick_byte(), pick_byte());
      wait_results_drained();
   endtask

   // Hold the output for a long stretch so the pipeline fills and stalls input
   task automatic test_output_hold();
      idle_pct  = 0;
      stall_pct = 0;
      hold_left = HOLD_CYCLES;
      repeat (25)
         send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
      wait_results_drained();
   endtask

   // Receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each accepted pixel with the oldest prediction
   always @(negedge clock) begin
      rgb_pixel_type got;
      rgb_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rgb_pixel_type'(rsp_tdata);
         if (expected_rgb_q.size() == 0) begin
            $error("unexpected pixel: red %0d green %0d blue %0d",
                   got.red, got.green, got.blue);
            mismatch_count++;
         end else begin
            want = expected_rgb_q.pop_front();
            pixels_checked++;
            if (got.red !== want.red) begin
               $error("red: expected %0d, actual %0d", want.red, got.red);
               mismatch_count++;
            end
            if (got.green !== want.green) begin
               $error("green: expected %0d, actual %0d", want.green, got.green);
               mismatch_count++;
            end
            if (got.blue !== want.blue) begin
               $error("blue: expected %0d, actual %0d", want.blue, got.blue);
               mismatch_count++;
            end
         end
      end
   end

   // Test sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_pixels();
      test_random_pixels(100, 0, 0);
      test_random_pixels(100, 61, 0);
      test_random_pixels(100, 0, 61);
      test_random_pixels(100, 19, 19);
      test_output_hold();
      $display("Sent %0d pixels, checked %0d: all hue sectors, grey and full-turn hues,",
               pixels_sent, pixels_checked);
      $display("range ends, random idle and stall mixes and a long output hold-off.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_sector.sv
rtl/core/hsvrgb_levels.sv
rtl/core/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_converter_tb.sv
